>>> sv/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// Shared constants and controller/datapath handshake types for the interval
// reservation table.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_TIME_BITS   = 16;
    localparam int MODE_BITS       = 2;
    localparam int ROOM_BITS       = 16;
    localparam int FOUND_BITS      = 16;
    localparam int USED_BITS       = 5;

    localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_FIND   = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // latch the incoming operation, restart the scan
        logic scan;     // walk the table one entry a cycle
        logic decide;   // settle the outcome, preset the shift pointer
        logic up;       // open a hole by moving entries up
        logic dn;       // close the hole by moving entries down
        logic put;      // write the new entry / update the count
        logic result;   // load the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic fit;
        logic full;
        logic hit;
        logic is_insert;
        logic is_remove;
        logic up_done;
        logic dn_done;
    } t_status;

endpackage

>>> sv/irt_datapath.sv
// ----------------------------------------------------------------------------
// irt_datapath
// Entry memory, scan and shift pointers, placement flags and the result
// register of the interval reservation table.
// ----------------------------------------------------------------------------
module irt_datapath import irt_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [MODE_BITS-1:0]  i_mode,
    input  logic [TIME_BITS-1:0]  i_begin_time,
    input  logic [TIME_BITS-1:0]  i_end_time,
    input  logic [ROOM_BITS-1:0]  i_room_number,
    output logic                  o_success,
    output logic                  o_table_full,
    output logic [FOUND_BITS-1:0] o_found_end,
    output logic [FOUND_BITS-1:0] o_found_room,
    output logic [USED_BITS-1:0]  o_entries_used
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = 2 * TIME_BITS + ROOM_BITS;

    logic [EW-1:0]        r_mem [TABLE_DEPTH];

    logic [MODE_BITS-1:0] r_mode;
    logic [TIME_BITS-1:0] r_b;
    logic [TIME_BITS-1:0] r_e;
    logic [ROOM_BITS-1:0] r_room;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_ptr;
    logic                 r_rvld;
    logic [CW-1:0]        r_rpos;
    logic [EW-1:0]        r_rdata;
    logic                 r_hit;
    logic [CW-1:0]        r_pos;
    logic                 r_gap;
    logic [CW-1:0]        r_gpos;
    logic                 r_back;
    logic [TIME_BITS-1:0] r_prev_end;
    logic [TIME_BITS-1:0] r_fend;
    logic [ROOM_BITS-1:0] r_froom;
    logic                 r_ok;
    logic                 r_full;

    logic                  r_success;
    logic                  r_table_full;
    logic [FOUND_BITS-1:0] r_found_end;
    logic [FOUND_BITS-1:0] r_found_room;
    logic [USED_BITS-1:0]  r_entries_used;

    logic                 is_insert;
    logic                 is_remove;
    logic                 is_find;
    logic [TIME_BITS-1:0] d_begin;
    logic [TIME_BITS-1:0] d_end;
    logic [ROOM_BITS-1:0] d_room;
    logic                 fit;
    logic                 full;
    logic [CW-1:0]        ins_pos;
    logic                 rd_en;
    logic [CW-1:0]        rd_addr;
    logic                 wr_en;
    logic [CW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic [CW-1:0]        n_ptr;

    assign is_insert = (r_mode == MODE_INSERT);
    assign is_remove = (r_mode == MODE_REMOVE);
    assign is_find   = (r_mode == MODE_FIND);

    assign d_begin = r_rdata[EW-1 -: TIME_BITS];
    assign d_end   = r_rdata[ROOM_BITS +: TIME_BITS];
    assign d_room  = r_rdata[ROOM_BITS-1:0];

    // Front fit beats back fit, back fit beats the first gap
    assign fit  = (r_count == '0) || r_hit || r_back || r_gap;
    assign full = (r_count >= CW'(TABLE_DEPTH));

    always_comb begin
        if (r_count == '0 || r_hit) begin
            ins_pos = '0;
        end else if (r_back) begin
            ins_pos = r_count;
        end else begin
            ins_pos = r_gpos;
        end
    end

    // Read port: one entry a cycle during the scan and both shifts
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ptr;
        priority if (i_cmd.scan) begin
            rd_en = (r_ptr < r_count) && !r_hit;
        end else if (i_cmd.up) begin
            rd_en   = (r_ptr > r_pos);
            rd_addr = r_ptr - CW'(1);
        end else if (i_cmd.dn) begin
            rd_en = (r_ptr < r_count);
        end else begin
            rd_en = 1'b0;
        end
    end

    // Write port: the entry read last cycle lands one place up or down; an insert writes the new entry at put
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = {r_b, r_e, r_room};
        priority if (i_cmd.up && r_rvld) begin
            wr_en   = 1'b1;
            wr_addr = r_rpos + CW'(1);
            wr_data = r_rdata;
        end else if (i_cmd.dn && r_rvld) begin
            wr_en   = 1'b1;
            wr_addr = r_rpos - CW'(1);
            wr_data = r_rdata;
        end else if (i_cmd.put && is_insert) begin
            wr_en = 1'b1;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        priority if (i_cmd.load) begin
            n_ptr = '0;
        end else if (i_cmd.decide) begin
            n_ptr = is_insert ? r_count : (r_pos + CW'(1));
        end else if (i_cmd.up && rd_en) begin
            n_ptr = r_ptr - CW'(1);
        end else if ((i_cmd.scan || i_cmd.dn) && rd_en) begin
            n_ptr = r_ptr + CW'(1);
        end else begin
            n_ptr = r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr[AW-1:0]];
            r_rpos  <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
            r_rvld  <= 1'b0;
            r_hit   <= 1'b0;
            r_gap   <= 1'b0;
            r_back  <= 1'b0;
        end else begin
            r_ptr  <= n_ptr;
            r_rvld <= rd_en;
            if (i_cmd.load) begin
                r_hit  <= 1'b0;
                r_gap  <= 1'b0;
                r_back <= 1'b0;
            end else if (i_cmd.scan && r_rvld && !r_hit) begin
                if (is_insert) begin
                    if (r_rpos == '0) begin
                        r_hit <= (d_begin >= r_e);
                    end else if (!r_gap && r_b >= r_prev_end && r_e <= d_begin) begin
                        r_gap <= 1'b1;
                    end
                    if (r_rpos == r_count - CW'(1)) begin
                        r_back <= (d_end <= r_b);
                    end
                end else begin
                    r_hit <= (d_begin == r_b);
                end
            end
            if (i_cmd.put) begin
                r_count <= is_insert ? (r_count + CW'(1)) : (r_count - CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_b    <= i_begin_time;
            r_e    <= i_end_time;
            r_room <= i_room_number;
        end
        if (i_cmd.scan && r_rvld && !r_hit) begin
            if (is_insert) begin
                r_prev_end <= d_end;
                if (r_rpos != '0 && !r_gap && r_b >= r_prev_end && r_e <= d_begin) begin
                    r_gpos <= r_rpos;
                end
            end else if (d_begin == r_b) begin
                r_pos   <= r_rpos;
                r_fend  <= d_end;
                r_froom <= d_room;
            end
        end
        if (i_cmd.decide) begin
            if (is_insert) begin
                r_pos <= ins_pos;
            end
            r_ok   <= is_insert ? (fit && !full) : ((is_remove || is_find) && r_hit);
            r_full <= is_insert && fit && full;
        end
        if (i_cmd.result) begin
            r_success      <= r_ok;
            r_table_full   <= r_full;
            r_found_end    <= (is_find && r_ok) ? FOUND_BITS'(r_fend) : '0;
            r_found_room   <= (is_find && r_ok) ? r_froom : '0;
            r_entries_used <= USED_BITS'(r_count);
        end
    end

    always_comb begin
        o_status.scan_done = !r_rvld && (r_hit || !(r_ptr < r_count));
        o_status.fit       = fit;
        o_status.full      = full;
        o_status.hit       = r_hit;
        o_status.is_insert = is_insert;
        o_status.is_remove = is_remove;
        o_status.up_done   = !r_rvld && !(r_ptr > r_pos);
        o_status.dn_done   = !r_rvld && !(r_ptr < r_count);
    end

    assign o_success      = r_success;
    assign o_table_full   = r_table_full;
    assign o_found_end    = r_found_end;
    assign o_found_room   = r_found_room;
    assign o_entries_used = r_entries_used;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put && is_insert) |-> (r_count < CW'(TABLE_DEPTH)))
        else $error("insert committed into a full table");

    a_remove_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put && !is_insert) |-> (r_count != '0 && r_hit))
        else $error("remove committed without a matching entry");

endmodule

>>> sv/irt_ctrl.sv
// ----------------------------------------------------------------------------
// irt_ctrl
// Sequencer of the interval reservation table: input and output handshake,
// scan, decision, shift and commit phases.
// ----------------------------------------------------------------------------
module irt_ctrl import irt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UP,
        S_DN,
        S_PUT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = (r_state == S_IDLE) && i_in_valid && !r_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.decide = (r_state == S_DECIDE);
        o_cmd.up     = (r_state == S_UP);
        o_cmd.dn     = (r_state == S_DN);
        o_cmd.put    = (r_state == S_PUT);
        o_cmd.result = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (i_status.is_insert && i_status.fit && !i_status.full) begin
                    n_state = S_UP;
                end else if (i_status.is_remove && i_status.hit) begin
                    n_state = S_DN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UP: begin
                if (i_status.up_done) n_state = S_PUT;
            end
            S_DN: begin
                if (i_status.dn_done) n_state = S_PUT;
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
            // hold the result until the receiver takes it
            if (o_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten before transfer");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_stall |-> (r_state == S_IDLE))
        else $error("input open while an operation is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("result dropped while the receiver stalls");

endmodule

>>> sv/interval_reservation_table.sv
// ----------------------------------------------------------------------------
// interval_reservation_table
// Sorted, non-overlapping table of time-slot reservations with insert,
// remove-by-begin and find-by-begin operations.
// ----------------------------------------------------------------------------
// Usage: an operation (mode, begin, end, room) is transferred on the input
// channel when i_in_valid is high and o_in_stall is low. Each operation gives
// exactly one result on the output channel, transferred when o_out_valid is
// high and i_out_stall is low.
// One operation is in flight at a time. An operation takes a scan of the
// entry memory at one entry a cycle, a decision, a shift through the
// single-read, single-write memory port at one entry a cycle and a commit
// (both for a successful insert or remove only), and the load of the output
// register. The memory read port sets the pace of the scan and the shift.
// The output register holds its result while the receiver stalls; the next
// operation may be transferred and worked on meanwhile, and waits to present
// its result until the previous one has gone.
// Reset (synchronous, active low) empties the table and drops the output
// valid; the input is open from the first cycle after reset. Entry contents
// are not cleared, as only entries below the count are read.
// ----------------------------------------------------------------------------
module interval_reservation_table import irt_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MODE_BITS-1:0]  i_mode,
    input  logic [TIME_BITS-1:0]  i_begin_time,
    input  logic [TIME_BITS-1:0]  i_end_time,
    input  logic [ROOM_BITS-1:0]  i_room_number,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_success,
    output logic                  o_table_full,
    output logic [FOUND_BITS-1:0] o_found_end,
    output logic [FOUND_BITS-1:0] o_found_room,
    output logic [USED_BITS-1:0]  o_entries_used
);

    t_cmd    cmd;
    t_status status;

    irt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    irt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_mode),
        .i_begin_time   (i_begin_time),
        .i_end_time     (i_end_time),
        .i_room_number  (i_room_number),
        .o_success      (o_success),
        .o_table_full   (o_table_full),
        .o_found_end    (o_found_end),
        .o_found_room   (o_found_room),
        .o_entries_used (o_entries_used)
    );

endmodule

>>> dv/interval_reservation_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_reservation_table_test
// Self-checking test of the interval reservation table. Operations are sent
// over the valid/stall input channel, and a shadow copy of the table predicts
// each result. The results are compared field by field as they leave the
// output channel. Directed cases cover placement at the front, at the back
// and in a gap, overlaps, zero-length and reversed slots, duplicate begins,
// the full table and the unused mode. Back-pressure, drain pauses and random
// traffic follow.
// ----------------------------------------------------------------------------
module interval_reservation_table_test;
    import irt_pkg::*;

    localparam int DEPTH         = DEF_TABLE_DEPTH;
    localparam int TBITS         = DEF_TIME_BITS;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam int LONG_HOLD     = 300;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic                  success;
        logic                  table_full;
        logic [FOUND_BITS-1:0] found_end;
        logic [FOUND_BITS-1:0] found_room;
        logic [USED_BITS-1:0]  entries_used;
    } t_booking_outcome;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic [MODE_BITS-1:0]  i_mode        = MODE_INSERT;
    logic [TBITS-1:0]      i_begin_time  = '0;
    logic [TBITS-1:0]      i_end_time    = '0;
    logic [ROOM_BITS-1:0]  i_room_number = '0;
    logic                  i_out_stall   = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_success;
    logic                  o_table_full;
    logic [FOUND_BITS-1:0] o_found_end;
    logic [FOUND_BITS-1:0] o_found_room;
    logic [USED_BITS-1:0]  o_entries_used;

    interval_reservation_table #(
        .TABLE_DEPTH (DEPTH),
        .TIME_BITS   (TBITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_begin_time   (i_begin_time),
        .i_end_time     (i_end_time),
        .i_room_number  (i_room_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_success      (o_success),
        .o_table_full   (o_table_full),
        .o_found_end    (o_found_end),
        .o_found_room   (o_found_room),
        .o_entries_used (o_entries_used)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the reservations, kept sorted the way the block keeps them
    logic [TBITS-1:0]     book_begin [DEPTH];
    logic [TBITS-1:0]     book_end   [DEPTH];
    logic [ROOM_BITS-1:0] book_room  [DEPTH];
    int                   book_count = 0;

    t_booking_outcome pending_outcomes[$];
    int mismatches   = 0;
    bit in_gaps_on   = 1'b0;
    bit out_gaps_on  = 1'b0;
    int hold_req     = 0;
    int hold_left    = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    function automatic t_booking_outcome apply_booking(input logic [MODE_BITS-1:0] mode,
                                                       input logic [TBITS-1:0] b,
                                                       input logic [TBITS-1:0] e,
                                                       input logic [ROOM_BITS-1:0] room);
        t_booking_outcome res;
        int   pos;
        int   idx;
        logic fits;
        res  = '0;
        pos  = 0;
        fits = 1'b0;
        unique case (mode)
            MODE_INSERT: begin
                if (book_count == 0 || book_begin[0] >= e) begin
                    fits = 1'b1;
                    pos  = 0;
                end else if (book_end[book_count-1] <= b) begin
                    fits = 1'b1;
                    pos  = book_count;
                end else begin
                    // first gap only
                    for (idx = 1; idx < book_count && !fits; idx++) begin
                        if (b >= book_end[idx-1] && e <= book_begin[idx]) begin
                            fits = 1'b1;
                            pos  = idx;
                        end
                    end
                end
                if (fits && book_count >= DEPTH) begin
                    res.table_full = 1'b1;
                end else if (fits) begin
                    for (idx = book_count; idx > pos; idx--) begin
                        book_begin[idx] = book_begin[idx-1];
                        book_end[idx]   = book_end[idx-1];
                        book_room[idx]  = book_room[idx-1];
                    end
                    book_begin[pos] = b;
                    book_end[pos]   = e;
                    book_room[pos]  = room;
                    book_count++;
                    res.success = 1'b1;
                end
            end
            MODE_REMOVE, MODE_FIND: begin
                pos = book_count;
                for (idx = 0; idx < book_count; idx++) begin
                    if (pos == book_count && book_begin[idx] == b)
                        pos = idx;
                end
                if (pos < book_count) begin
                    res.success = 1'b1;
                    if (mode == MODE_FIND) begin
                        res.found_end  = book_end[pos];
                        res.found_room = book_room[pos];
                    end else begin
                        for (idx = pos; idx + 1 < book_count; idx++) begin
                            book_begin[idx] = book_begin[idx+1];
                            book_end[idx]   = book_end[idx+1];
                            book_room[idx]  = book_room[idx+1];
                        end
                        book_count--;
                    end
                end
            end
            default: ;
        endcase
        res.entries_used = USED_BITS'(book_count);
        return res;
    endfunction

    task automatic send_booking(input logic [MODE_BITS-1:0] mode, input logic [TBITS-1:0] b,
                                input logic [TBITS-1:0] e, input logic [ROOM_BITS-1:0] room);
        int gap;
        gap = (in_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_begin_time  <= b;
        i_end_time    <= e;
        i_room_number <= room;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_outcomes.push_back(apply_booking(mode, b, e, room));
    endtask

    task automatic send_random_booking(input int insert_pct);
        int roll;
        int p;
        int lo;
        int hi;
        int b;
        int e;
        logic [MODE_BITS-1:0] mode;
        roll = $urandom_range(0, 99);
        b    = $urandom_range(0, 65535);
        e    = $urandom_range(0, 65535);
        if (roll < insert_pct) begin
            mode = MODE_INSERT;
            p    = $urandom_range(0, 9);
            if (p < 6) begin
                // aim a short slot at a gap that is known to be free
                p  = $urandom_range(0, book_count);
                lo = (p == 0) ? 0 : int'(book_end[p-1]);
                hi = (p == book_count) ? 65535 : int'(book_begin[p]);
                if (lo <= hi) begin
                    b = lo + $urandom_range(0, (hi - lo < 2048) ? hi - lo : 2048);
                    e = b + $urandom_range(0, (hi - b < 512) ? hi - b : 512);
                end
            end else if (p < 9) begin
                e = b + $urandom_range(0, 256);
            end
        end else if (roll < insert_pct + (96 - insert_pct) / 2) begin
            mode = MODE_REMOVE;
        end else if (roll < 96) begin
            mode = MODE_FIND;
        end else begin
            mode = MODE_UNUSED;
        end
        if (mode != MODE_INSERT && book_count > 0 && $urandom_range(0, 9) < 7)
            b = book_begin[$urandom_range(0, book_count - 1)];
        send_booking(mode, TBITS'(b), TBITS'(e), ROOM_BITS'($urandom_range(0, 65535)));
    endtask

    // Drop valid, then wait for every outstanding result
    task automatic drain_outcomes();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        int k;
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
        send_booking(MODE_FIND,   16'h0800, 16'h0000, 16'h0000);
        send_booking(MODE_REMOVE, 16'h0800, 16'h0000, 16'h0000);
        send_booking(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_booking(MODE_INSERT, 16'h0800, 16'h0900, 16'hFFFF);
        send_booking(MODE_INSERT, 16'h0000, 16'h0800, 16'h0000);
        send_booking(MODE_INSERT, 16'hF000, 16'hFFFF, 16'h1234);
        send_booking(MODE_INSERT, 16'h0900, 16'h0A00, 16'h0A0A);
        send_booking(MODE_INSERT, 16'h0850, 16'h0950, 16'h0001);
        // zero-length and reversed slots pass straight to placement
        send_booking(MODE_INSERT, 16'h0800, 16'h0800, 16'h5555);
        send_booking(MODE_INSERT, 16'h0C00, 16'h0B00, 16'hAAAA);
        // two entries now begin at 0800: only the first is seen
        send_booking(MODE_FIND,   16'h0800, 16'h0000, 16'h0000);
        send_booking(MODE_REMOVE, 16'h0800, 16'h0000, 16'h0000);
        send_booking(MODE_FIND,   16'h0800, 16'h0000, 16'h0000);
        send_booking(MODE_FIND,   16'h1234, 16'h0000, 16'h0000);
        send_booking(MODE_REMOVE, 16'h0000, 16'h0000, 16'h0000);
        for (k = 0; book_count < DEPTH - 1; k++)
            send_booking(MODE_INSERT, TBITS'(32'h2000 + k * 256), TBITS'(32'h2080 + k * 256),
                         ROOM_BITS'(k));
        send_booking(MODE_INSERT, 16'hFFFF, 16'hFFFF, 16'h8001);
        send_booking(MODE_INSERT, 16'h0000, 16'h0000, 16'h7777);
        send_booking(MODE_INSERT, 16'h0850, 16'h0860, 16'h0002);
        send_booking(MODE_FIND,   16'hFFFF, 16'h0000, 16'h0000);
        send_booking(MODE_REMOVE, 16'hFFFF, 16'h0000, 16'h0000);
        drain_outcomes();
    endtask

    // Hold the output off for a long stretch while operations keep coming
    task automatic test_backpressure();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        @(posedge i_clk) hold_req = LONG_HOLD;
        repeat (24) send_random_booking(50);
        drain_outcomes();
    endtask

    task automatic test_drain_pause();
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
        repeat (3) begin
            repeat (8) send_random_booking(45);
            drain_outcomes();
        end
    endtask

    task automatic test_random_mix();
        int seg;
        int insert_pct [4] = '{60, 25, 45, 45};
        for (seg = 0; seg < 4; seg++) begin
            // odd phases and the last one run without idling
            in_gaps_on  = (seg % 2 == 0);
            out_gaps_on = (seg % 2 == 0);
            repeat (280) send_random_booking(insert_pct[seg]);
        end
        drain_outcomes();
    endtask

    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (out_gaps_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_outcomes
        t_booking_outcome want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with no operation outstanding");
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                compare_field("success", 16'(want.success), 16'(o_success));
                compare_field("table_full", 16'(want.table_full), 16'(o_table_full));
                compare_field("found_end", want.found_end, o_found_end);
                compare_field("found_room", want.found_room, o_found_room);
                compare_field("entries_used", 16'(want.entries_used), 16'(o_entries_used));
            end
        end
    end

    // End the run when no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random_mix();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
sv/irt_pkg.sv
sv/irt_datapath.sv
sv/irt_ctrl.sv
sv/interval_reservation_table.sv
dv/interval_reservation_table_test.sv
